[sv/rme_pkg.sv]
// Shared types and constants of the modular exponentiation block.
`default_nettype none
package rme_pkg;

   // Register indexes of the configuration port.
   localparam logic CSR_MODULUS  = 1'b0;
   localparam logic CSR_EXPONENT = 1'b1;

   // Reset values of the configuration registers.
   localparam int unsigned RESET_MODULUS  = 7196911;
   localparam int unsigned RESET_EXPONENT = 999983;

   // Operand selection of the shared modular multiplier.
   localparam logic [1:0] SEL_REDUCE = 2'd0;  // 1 * base, reduces the base
   localparam logic [1:0] SEL_MULR   = 2'd1;  // base * result into result
   localparam logic [1:0] SEL_SQR    = 2'd2;  // base * base into base

   typedef struct packed {
      logic       load;
      logic       mul_go;
      logic [1:0] mul_sel;
      logic       exp_shift;
      logic       respond;
   } cmd_type;

   typedef struct packed {
      logic mul_done;
      logic exp_bit;
   } status_type;

endpackage
`default_nettype wire

[sv/rme_ctrl.sv]
// Sequencer of the modular exponentiation: walks the exponent bits and issues multiplies.
`default_nettype none
module rme_ctrl
   import rme_pkg::*;
#(
   parameter int MOD_BITS = 24
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire status_type status,
   output cmd_type         cmd
);

   localparam int CNT_BITS = $clog2(MOD_BITS);

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_RED_GO    = 3'd1;
   localparam logic [2:0] ST_RED_WAIT  = 3'd2;
   localparam logic [2:0] ST_BIT       = 3'd3;
   localparam logic [2:0] ST_MULR_WAIT = 3'd4;
   localparam logic [2:0] ST_SQR_WAIT  = 3'd5;
   localparam logic [2:0] ST_DONE      = 3'd6;

   logic [2:0]          state_ff;
   logic [2:0]          state_in;
   logic [CNT_BITS-1:0] bit_cnt_ff;
   logic [CNT_BITS-1:0] bit_cnt_in;

   always_comb begin
      state_in      = state_ff;
      bit_cnt_in    = bit_cnt_ff;
      cmd           = '0;
      cmd.mul_sel   = SEL_REDUCE;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_RED_GO;
            end
         end
         ST_RED_GO: begin
            cmd.mul_go  = 1'b1;
            cmd.mul_sel = SEL_REDUCE;
            state_in    = ST_RED_WAIT;
         end
         ST_RED_WAIT: begin
            if (status.mul_done) begin
               bit_cnt_in = '0;
               state_in   = ST_BIT;
            end
         end
         ST_BIT: begin
            cmd.mul_go = 1'b1;
            if (status.exp_bit) begin
               cmd.mul_sel = SEL_MULR;
               state_in    = ST_MULR_WAIT;
            end else begin
               cmd.mul_sel = SEL_SQR;
               state_in    = ST_SQR_WAIT;
            end
         end
         ST_MULR_WAIT: begin
            if (status.mul_done) begin
               cmd.mul_go  = 1'b1;
               cmd.mul_sel = SEL_SQR;
               state_in    = ST_SQR_WAIT;
            end
         end
         ST_SQR_WAIT: begin
            if (status.mul_done) begin
               cmd.exp_shift = 1'b1;
               if (bit_cnt_ff == CNT_BITS'(MOD_BITS - 1)) begin
                  state_in = ST_DONE;
               end else begin
                  bit_cnt_in = bit_cnt_ff + 1'b1;
                  state_in   = ST_BIT;
               end
            end
         end
         ST_DONE: begin
            cmd.respond = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         bit_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         bit_cnt_ff <= bit_cnt_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

`ifndef ASSERT_OFF
   a_respond_then_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.respond |=> (state_ff == ST_IDLE))
      else $error("sequencer did not return to idle after a result");

   a_done_only_when_waiting: assert property (@(posedge clock) disable iff (reset)
      status.mul_done |-> (state_ff == ST_RED_WAIT || state_ff == ST_MULR_WAIT ||
                           state_ff == ST_SQR_WAIT))
      else $error("multiplier finished with no multiply outstanding");

   a_busy_needs_start: assert property (@(posedge clock) disable iff (reset)
      (busy && !$past(busy)) |-> $past(start))
      else $error("sequencer left idle without a start");
`endif

endmodule
`default_nettype wire

[sv/rme_dpath.sv]
// Datapath: operand registers and the interleaved shift-add modular multiplier.
`default_nettype none
module rme_dpath
   import rme_pkg::*;
#(
   parameter int MOD_BITS = 24
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cmd_type             cmd,
   output status_type               status,
   input  wire logic [MOD_BITS-1:0] base_value,
   input  wire logic                end_of_message,
   input  wire logic [MOD_BITS-1:0] modulus,
   input  wire logic [MOD_BITS-1:0] exponent,
   output logic      [MOD_BITS-1:0] power_result,
   output logic                     end_of_message_out
);

   localparam int W         = MOD_BITS + 2;
   localparam int STEP_BITS = $clog2(MOD_BITS + 1);

   logic [MOD_BITS-1:0]  base_ff;
   logic [MOD_BITS-1:0]  result_ff;
   logic [MOD_BITS-1:0]  exp_ff;
   logic [MOD_BITS-1:0]  m_ff;
   logic                 flag_ff;
   logic [MOD_BITS-1:0]  a_ff;
   logic [MOD_BITS-1:0]  b_ff;
   logic [MOD_BITS-1:0]  acc_ff;
   logic [1:0]           sel_ff;
   logic [STEP_BITS-1:0] step_ff;
   logic                 done_ff;

   logic [W-1:0]         t;
   logic [W-1:0]         m1;
   logic [W-1:0]         m2;
   logic [W-1:0]         t_m1;
   logic [W-1:0]         t_m2;
   logic [MOD_BITS-1:0]  acc_in;
   logic                 running;
   logic                 finish;

   // One bit of the multiplier per cycle, MSB first: acc = 2*acc + bit*a, then
   // reduce. The sum stays below 3m, so the three candidates cover every case.
   always_comb begin
      t    = {1'b0, acc_ff, 1'b0} + (b_ff[MOD_BITS-1] ? {2'b00, a_ff} : '0);
      m1   = {2'b00, m_ff};
      m2   = {1'b0, m_ff, 1'b0};
      t_m1 = t - m1;
      t_m2 = t - m2;
      priority if (t >= m2) begin
         acc_in = t_m2[MOD_BITS-1:0];
      end else if (t >= m1) begin
         acc_in = t_m1[MOD_BITS-1:0];
      end else begin
         acc_in = t[MOD_BITS-1:0];
      end
   end

   assign running = (step_ff != '0);
   assign finish  = (step_ff == STEP_BITS'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= finish;
         if (cmd.mul_go) begin
            step_ff <= STEP_BITS'(MOD_BITS);
         end else if (running) begin
            step_ff <= step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         base_ff   <= base_value;
         result_ff <= MOD_BITS'(1);
         exp_ff    <= exponent;
         m_ff      <= modulus;
         flag_ff   <= end_of_message;
      end
      if (cmd.exp_shift) begin
         exp_ff <= exp_ff >> 1;
      end
      if (cmd.mul_go) begin
         acc_ff <= '0;
         sel_ff <= cmd.mul_sel;
         unique case (cmd.mul_sel)
            SEL_REDUCE: begin
               a_ff <= MOD_BITS'(1);
               b_ff <= base_ff;
            end
            SEL_MULR: begin
               a_ff <= base_ff;
               b_ff <= result_ff;
            end
            default: begin
               a_ff <= base_ff;
               b_ff <= base_ff;
            end
         endcase
      end else if (running) begin
         acc_ff <= acc_in;
         b_ff   <= b_ff << 1;
         if (finish) begin
            if (sel_ff == SEL_MULR) begin
               result_ff <= acc_in;
            end else begin
               base_ff <= acc_in;
            end
         end
      end
   end

   assign status.mul_done = done_ff;
   assign status.exp_bit  = exp_ff[0];

   // A modulus of zero or one has only the residue zero.
   assign power_result       = (m_ff < MOD_BITS'(2)) ? '0 : result_ff;
   assign end_of_message_out = flag_ff;

endmodule
`default_nettype wire

[sv/rsa_modular_exponentiation_top.sv]
// Top level of the modular exponentiation block: registers, sequencer, datapath, result port.
`default_nettype none
// Computes base^exponent mod modulus for each accepted beat by right-to-left
// square-and-multiply; the end-of-message flag travels with the value. A beat
// is taken when start is high and busy is low, and one result appears for one
// cycle on rsp_valid; the receiver cannot stall it, so it must sample then.
// Every modular product is done by one shared shift-add multiplier, which raises a
// done flag when it finishes. After the accepting edge busy stays high through the
// base reduction, then for each of the MOD_BITS exponent bits a multiply into the
// result (bit set only) and a squaring of the base, then a closing state.
// The result is on the rsp_ ports in the first cycle with busy low again.
// Write csr_ registers only while busy is low.
module rsa_modular_exponentiation_top
   import rme_pkg::*;
#(
   parameter int MOD_BITS = 24
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic [MOD_BITS-1:0] req_base_value,
   input  wire logic                req_end_of_message,
   output logic                     rsp_valid,
   output logic      [MOD_BITS-1:0] rsp_power_result,
   output logic                     rsp_end_of_message_out,
   input  wire logic                csr_write_enable,
   input  wire logic                csr_index,
   input  wire logic [MOD_BITS-1:0] csr_write_data
);

   logic [MOD_BITS-1:0] modulus_ff;
   logic [MOD_BITS-1:0] exponent_ff;
   logic                rsp_valid_ff;
   logic [MOD_BITS-1:0] rsp_power_result_ff;
   logic                rsp_eom_ff;

   cmd_type             cmd;
   status_type          status;
   logic [MOD_BITS-1:0] dp_result;
   logic                dp_eom;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff  <= MOD_BITS'(RESET_MODULUS);
         exponent_ff <= MOD_BITS'(RESET_EXPONENT);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MODULUS:  modulus_ff  <= csr_write_data;
            CSR_EXPONENT: exponent_ff <= csr_write_data;
            default:      modulus_ff  <= modulus_ff;
         endcase
      end
   end

   rme_ctrl #(
      .MOD_BITS(MOD_BITS)
   ) u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   rme_dpath #(
      .MOD_BITS(MOD_BITS)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .base_value         (req_base_value),
      .end_of_message     (req_end_of_message),
      .modulus            (modulus_ff),
      .exponent           (exponent_ff),
      .power_result       (dp_result),
      .end_of_message_out (dp_eom)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.respond;
      end
      if (cmd.respond) begin
         rsp_power_result_ff <= dp_result;
         rsp_eom_ff          <= dp_eom;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_power_result       = rsp_power_result_ff;
   assign rsp_end_of_message_out = rsp_eom_ff;

endmodule
`default_nettype wire

[tb/sv/modexp_checker.sv]
// Checker of the modular exponentiation block: predicts each result and compares it.
`default_nettype none
module modexp_checker
   import rme_pkg::*;
#(
   parameter int MOD_BITS = 24
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic                busy,
   input  wire logic [MOD_BITS-1:0] req_base_value,
   input  wire logic                req_end_of_message,
   input  wire logic                rsp_valid,
   input  wire logic [MOD_BITS-1:0] rsp_power_result,
   input  wire logic                rsp_end_of_message_out,
   input  wire logic                csr_write_enable,
   input  wire logic                csr_index,
   input  wire logic [MOD_BITS-1:0] csr_write_data,
   output int                       fail_count,
   output int                       outstanding
);

   typedef struct packed {
      logic [MOD_BITS-1:0] power;
      logic                eom;
   } power_expectation_type;

   power_expectation_type pending_powers[$];
   logic [MOD_BITS-1:0]   modulus_copy;
   logic [MOD_BITS-1:0]   exponent_copy;

   // Right-to-left square-and-multiply; products are held at twice the width.
   function automatic logic [MOD_BITS-1:0] mod_power(input logic [MOD_BITS-1:0] base,
                                                     input logic [MOD_BITS-1:0] exp,
                                                     input logic [MOD_BITS-1:0] m);
      logic [2*MOD_BITS-1:0] acc;
      logic [2*MOD_BITS-1:0] sq;
      logic [2*MOD_BITS-1:0] wide_m;
      wide_m = {{MOD_BITS{1'b0}}, m};
      if (m < 2) return '0;
      sq  = {{MOD_BITS{1'b0}}, base} % wide_m;
      acc = 1;
      for (int i = 0; i < MOD_BITS; i++) begin
         if (exp[i]) acc = (acc * sq) % wide_m;
         sq = (sq * sq) % wide_m;
      end
      return acc[MOD_BITS-1:0];
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      fail_count++;
   endtask

   always @(posedge clock) begin : watch
      power_expectation_type head;
      if (reset) begin
         modulus_copy  = MOD_BITS'(RESET_MODULUS);
         exponent_copy = MOD_BITS'(RESET_EXPONENT);
         pending_powers.delete();
         outstanding <= 0;
      end else begin
         if (rsp_valid) begin
            if (pending_powers.size() == 0) begin
               report_mismatch($sformatf("result beat %h with nothing expected",
                                         rsp_power_result));
            end else begin
               head = pending_powers.pop_front();
               if (rsp_power_result !== head.power)
                  report_mismatch($sformatf("power_result %h, expected %h",
                                            rsp_power_result, head.power));
               if (rsp_end_of_message_out !== head.eom)
                  report_mismatch($sformatf("end_of_message_out %b, expected %b",
                                            rsp_end_of_message_out, head.eom));
            end
         end
         // The prediction uses the registers as they stood before this edge.
         if (start && !busy) begin
            head.power = mod_power(req_base_value, exponent_copy, modulus_copy);
            head.eom   = req_end_of_message;
            pending_powers.push_back(head);
         end
         if (csr_write_enable) begin
            if (csr_index == CSR_MODULUS) modulus_copy = csr_write_data;
            else exponent_copy = csr_write_data;
         end
         outstanding <= pending_powers.size();
      end
   end

endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
// Testbench top of the modular exponentiation block: clock, reset, stimulus and verdict.
`default_nettype none
module tb_top;
   import rme_pkg::*;

   localparam int MOD_BITS     = 24;
   localparam int CYCLE_LIMIT  = 8000000;
   localparam int DRAIN_CYCLES = 1300;
   localparam int PHASES       = 10;
   localparam int PHASE_BEATS  = 50;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [MOD_BITS-1:0] req_base_value;
   logic                req_end_of_message;
   logic                rsp_valid;
   logic [MOD_BITS-1:0] rsp_power_result;
   logic                rsp_end_of_message_out;
   logic                csr_write_enable;
   logic                csr_index;
   logic [MOD_BITS-1:0] csr_write_data;
   int                  fail_count;
   int                  outstanding;

   int                  idle_pct;
   logic [MOD_BITS-1:0] cur_modulus;

   rsa_modular_exponentiation_top #(.MOD_BITS(MOD_BITS)) u_dut (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_base_value         (req_base_value),
      .req_end_of_message     (req_end_of_message),
      .rsp_valid              (rsp_valid),
      .rsp_power_result       (rsp_power_result),
      .rsp_end_of_message_out (rsp_end_of_message_out),
      .csr_write_enable       (csr_write_enable),
      .csr_index              (csr_index),
      .csr_write_data         (csr_write_data)
   );

   modexp_checker #(.MOD_BITS(MOD_BITS)) u_checker (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_base_value         (req_base_value),
      .req_end_of_message     (req_end_of_message),
      .rsp_valid              (rsp_valid),
      .rsp_power_result       (rsp_power_result),
      .rsp_end_of_message_out (rsp_end_of_message_out),
      .csr_write_enable       (csr_write_enable),
      .csr_index              (csr_index),
      .csr_write_data         (csr_write_data),
      .fail_count             (fail_count),
      .outstanding            (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("** rsa_modular_exponentiation_top: FAILED **");
      $finish;
   end

   // Start stays high after an accepted beat unless a gap follows.
   task automatic send_beat(input logic [MOD_BITS-1:0] base, input logic eom);
      req_base_value     <= base;
      req_end_of_message <= eom;
      start              <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         if ($urandom_range(3) == 0) repeat ($urandom_range(1400, 1)) @(posedge clock);
         else repeat ($urandom_range(4, 1)) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0 || busy) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [MOD_BITS-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
   endtask

   task automatic configure(input logic [MOD_BITS-1:0] m, input logic [MOD_BITS-1:0] e);
      wait_idle();
      // A stray write now and then must be overwritten by the one that follows.
      if ($urandom_range(3) == 0) write_reg(CSR_EXPONENT, MOD_BITS'($urandom));
      if ($urandom_range(1)) begin
         write_reg(CSR_MODULUS, m);
         write_reg(CSR_EXPONENT, e);
      end else begin
         write_reg(CSR_EXPONENT, e);
         write_reg(CSR_MODULUS, m);
      end
      csr_write_enable <= 1'b0;
      cur_modulus = m;
      @(posedge clock);
   endtask

   function automatic logic [MOD_BITS-1:0] pick_modulus();
      case ($urandom_range(9))
         0:       return 2;
         1:       return '1;
         2:       return MOD_BITS'(RESET_MODULUS);
         3:       return MOD_BITS'($urandom_range(255, 2));
         4:       return MOD_BITS'($urandom_range(1));
         default: return MOD_BITS'($urandom);
      endcase
   endfunction

   function automatic logic [MOD_BITS-1:0] pick_exponent();
      case ($urandom_range(9))
         0:       return 0;
         1:       return '1;
         2:       return 1;
         3:       return MOD_BITS'(RESET_EXPONENT);
         4:       return MOD_BITS'($urandom_range(15));
         default: return MOD_BITS'($urandom);
      endcase
   endfunction

   function automatic logic [MOD_BITS-1:0] pick_base(input logic [MOD_BITS-1:0] m);
      logic [MOD_BITS-1:0] below;
      below = m - 1'b1;
      case ($urandom_range(9))
         0:       return 0;
         1:       return '1;
         2:       return below;
         3:       return m;
         4:       return m + 1'b1;
         5, 6:    return MOD_BITS'($urandom_range(below));
         default: return MOD_BITS'($urandom);
      endcase
   endfunction

   initial begin
      reset              = 1'b1;
      start              = 1'b0;
      req_base_value     = '0;
      req_end_of_message = 1'b0;
      csr_write_enable   = 1'b0;
      csr_index          = CSR_MODULUS;
      csr_write_data     = '0;
      idle_pct           = 0;
      cur_modulus        = MOD_BITS'(RESET_MODULUS);
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Key as it stands after reset: small bases, all ones, and bases at and around the modulus.
      send_beat(0, 1'b0);
      send_beat(1, 1'b1);
      send_beat('1, 1'b0);
      send_beat(MOD_BITS'(RESET_MODULUS - 1), 1'b0);
      send_beat(MOD_BITS'(RESET_MODULUS), 1'b1);
      send_beat(MOD_BITS'(RESET_MODULUS + 1), 1'b0);
      send_beat(72, 1'b1);

      configure('1, '1);
      send_beat(0, 1'b0);
      send_beat('1, 1'b1);
      send_beat(2, 1'b0);
      send_beat(24'h800000, 1'b1);

      // A zero exponent gives one, even for a zero base.
      configure(2, 0);
      send_beat(0, 1'b0);
      send_beat('1, 1'b1);
      send_beat(5, 1'b0);
      configure('1, 0);
      send_beat('1, 1'b1);

      // Moduli of one and zero leave no meaningful residue.
      configure(1, MOD_BITS'(RESET_EXPONENT));
      send_beat(5, 1'b1);
      send_beat(0, 1'b0);
      configure(0, '1);
      send_beat('1, 1'b1);
      send_beat(3, 1'b0);

      configure(2, '1);
      send_beat(3, 1'b1);
      send_beat(2, 1'b0);
      configure(MOD_BITS'(RESET_MODULUS), 1);
      send_beat(24'h123456, 1'b1);

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase % 3)
            0:       idle_pct = 0;
            1:       idle_pct = 47;
            default: idle_pct = 32;
         endcase
         configure(pick_modulus(), pick_exponent());
         for (int n = 0; n < PHASE_BEATS; n++) begin
            if (n == PHASE_BEATS / 2 && $urandom_range(1)) wait_idle();
            send_beat(pick_base(cur_modulus), $urandom_range(7) == 0);
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("** rsa_modular_exponentiation_top: PASSED **");
      else
         $display("** rsa_modular_exponentiation_top: FAILED **");
      $finish;
   end

endmodule
`default_nettype wire
